>>> rtl/sd3_pkg.sv
// shared constants for the 3d segment distance pipeline
`default_nettype none
package sd3_pkg;

  // default coordinate width of the input endpoints
  localparam int unsigned COORD_BITS_DEF = 32;
  // fraction bits of the two closest-point parameters
  localparam int unsigned QUOT_FRAC = 32;
  // width of the distance result
  localparam int unsigned DIST_BITS = 33;
  // cycles from an accepted request to its result strobe
  localparam int unsigned PIPE_LAT = 16 + QUOT_FRAC + DIST_BITS;

endpackage
`default_nettype wire

>>> rtl/sd3_mul.sv
// two-stage signed multiplier built from four half-width partial products
`default_nettype none
module sd3_mul
  import sd3_pkg::*;
#(
  parameter int unsigned W = COORD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic signed [W-1:0]   a_i,
  input  logic signed [W-1:0]   b_i,
  output logic signed [2*W-1:0] p_o
);

  localparam int unsigned H = (W + 1) / 2;
  localparam int unsigned G = W - H;

  logic [W-1:0]     a_u, b_u, mag_a, mag_b;
  logic [2*H-1:0]   ll_q;
  logic [H+G-1:0]   lh_q, hl_q;
  logic [2*G-1:0]   hh_q;
  logic             neg_q;
  logic [2*W-1:0]   sum;
  logic [2*W-1:0]   p_q;

  // magnitudes of both operands
  assign a_u   = a_i;
  assign b_u   = b_i;
  assign mag_a = a_u[W-1] ? (~a_u + W'(1)) : a_u;
  assign mag_b = b_u[W-1] ? (~b_u + W'(1)) : b_u;

  // stage one: partial products
  always_ff @(posedge clk_i) begin
    ll_q  <= mag_a[H-1:0] * mag_b[H-1:0];
    lh_q  <= mag_a[H-1:0] * mag_b[W-1:H];
    hl_q  <= mag_a[W-1:H] * mag_b[H-1:0];
    hh_q  <= mag_a[W-1:H] * mag_b[W-1:H];
    neg_q <= a_u[W-1] ^ b_u[W-1];
  end

  // stage two: combine and restore the sign
  assign sum = (2*W)'(ll_q) + ((2*W)'(lh_q) << H) + ((2*W)'(hl_q) << H)
             + ((2*W)'(hh_q) << (2*H));

  always_ff @(posedge clk_i) begin
    p_q <= neg_q ? (~sum + (2*W)'(1)) : sum;
  end

  assign p_o = p_q;

endmodule
`default_nettype wire

>>> rtl/segment_distance_3d.sv
// top level: fully pipelined shortest distance between two 3d segments
`default_nettype none
// Usage:
//   A request carries both endpoints of segment A and of segment B as signed
//   fixed-point coordinates. It is taken at a rising edge where start is high
//   and busy is low; busy never rises, so one request may enter every cycle.
//   The shortest distance, unsigned, same fixed-point format, is shown on
//   distance_o for exactly one cycle with done_o high, in request order.
//   Throughput is one request per cycle.
//   Latency is set by the two 32-step bit-per-stage dividers for the closest
//   point parameters and the 33-step bit-per-stage square root, plus the
//   two-stage multipliers for the dot products, the clamp terms and the
//   closest-point differences, and the register stages between them.
//   The receiver cannot hold results off, so nothing ever stalls.
//   Reset clears only the valid bits travelling with the data; requests in
//   flight are dropped and no result strobe appears for them.
module segment_distance_3d
  import sd3_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] seg_a_first_x_i,
  input  logic signed [COORD_BITS-1:0] seg_a_first_y_i,
  input  logic signed [COORD_BITS-1:0] seg_a_first_z_i,
  input  logic signed [COORD_BITS-1:0] seg_a_second_x_i,
  input  logic signed [COORD_BITS-1:0] seg_a_second_y_i,
  input  logic signed [COORD_BITS-1:0] seg_a_second_z_i,
  input  logic signed [COORD_BITS-1:0] seg_b_first_x_i,
  input  logic signed [COORD_BITS-1:0] seg_b_first_y_i,
  input  logic signed [COORD_BITS-1:0] seg_b_first_z_i,
  input  logic signed [COORD_BITS-1:0] seg_b_second_x_i,
  input  logic signed [COORD_BITS-1:0] seg_b_second_y_i,
  input  logic signed [COORD_BITS-1:0] seg_b_second_z_i,
  output logic                         done_o,
  output logic [DIST_BITS-1:0]         distance_o
);

  localparam int unsigned DW     = COORD_BITS + 1;
  localparam int unsigned DOTW   = 2 * DW + 2;
  localparam int unsigned QW     = 2 * DOTW + 1;
  localparam int unsigned SCW    = QUOT_FRAC + 2;
  localparam int unsigned MW     = (SCW > DW) ? SCW : DW;
  localparam int unsigned DPW    = 2 * MW + 2;
  localparam int unsigned SW     = 2 * DPW + 2;
  localparam int unsigned XW     = SW - 2 * QUOT_FRAC;
  localparam int unsigned RW     = (XW > 2 * DIST_BITS + 2) ? XW : 2 * DIST_BITS + 2;
  localparam int unsigned ST_DIV = 10 + QUOT_FRAC;
  localparam int unsigned ST_DP  = ST_DIV + 2;
  localparam int unsigned N_DL   = ST_DP - 1;

  typedef struct packed {
    logic signed [DOTW-1:0] a;
    logic signed [DOTW-1:0] b;
    logic signed [DOTW-1:0] c;
    logic signed [DOTW-1:0] d;
    logic signed [DOTW-1:0] e;
  } dot_t;

  // valid bits travel alongside the data
  logic [PIPE_LAT:1] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[PIPE_LAT-1:1], start};
    end
  end

  assign busy   = 1'b0;
  assign done_o = vld_q[PIPE_LAT];

  // stage 1: direction and offset vectors
  logic signed [COORD_BITS-1:0] a1 [3], a2 [3], b2 [3], b1 [3];
  logic signed [DW-1:0]         u1_q [3], v1_q [3], w1_q [3];

  assign a1[0] = seg_a_first_x_i;
  assign a1[1] = seg_a_first_y_i;
  assign a1[2] = seg_a_first_z_i;
  assign a2[0] = seg_a_second_x_i;
  assign a2[1] = seg_a_second_y_i;
  assign a2[2] = seg_a_second_z_i;
  assign b1[0] = seg_b_first_x_i;
  assign b1[1] = seg_b_first_y_i;
  assign b1[2] = seg_b_first_z_i;
  assign b2[0] = seg_b_second_x_i;
  assign b2[1] = seg_b_second_y_i;
  assign b2[2] = seg_b_second_z_i;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      u1_q[k] <= DW'(a1[k]) - DW'(a2[k]);
      v1_q[k] <= DW'(b1[k]) - DW'(b2[k]);
      w1_q[k] <= DW'(a2[k]) - DW'(b2[k]);
    end
  end

  // vectors delayed for the closest-point stage
  logic signed [DW-1:0] u_dl_q [N_DL][3], v_dl_q [N_DL][3], w_dl_q [N_DL][3];

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      u_dl_q[0][k] <= u1_q[k];
      v_dl_q[0][k] <= v1_q[k];
      w_dl_q[0][k] <= w1_q[k];
      for (int i = 1; i < N_DL; i++) begin
        u_dl_q[i][k] <= u_dl_q[i-1][k];
        v_dl_q[i][k] <= v_dl_q[i-1][k];
        w_dl_q[i][k] <= w_dl_q[i-1][k];
      end
    end
  end

  // stages 2-3: per-axis products for the dot products
  logic signed [2*DW-1:0] p_uu [3], p_uv [3], p_vv [3], p_uw [3], p_vw [3];

  for (genvar k = 0; k < 3; k++) begin : g_dot
    sd3_mul #(.W(DW)) u_uu (.clk_i, .a_i(u1_q[k]), .b_i(u1_q[k]), .p_o(p_uu[k]));
    sd3_mul #(.W(DW)) u_uv (.clk_i, .a_i(u1_q[k]), .b_i(v1_q[k]), .p_o(p_uv[k]));
    sd3_mul #(.W(DW)) u_vv (.clk_i, .a_i(v1_q[k]), .b_i(v1_q[k]), .p_o(p_vv[k]));
    sd3_mul #(.W(DW)) u_uw (.clk_i, .a_i(u1_q[k]), .b_i(w1_q[k]), .p_o(p_uw[k]));
    sd3_mul #(.W(DW)) u_vw (.clk_i, .a_i(v1_q[k]), .b_i(w1_q[k]), .p_o(p_vw[k]));
  end

  // stage 4: dot product sums
  dot_t dot4_q, dot5_q, dot6_q, dot7_q;

  always_ff @(posedge clk_i) begin
    dot4_q.a <= DOTW'(p_uu[0]) + DOTW'(p_uu[1]) + DOTW'(p_uu[2]);
    dot4_q.b <= DOTW'(p_uv[0]) + DOTW'(p_uv[1]) + DOTW'(p_uv[2]);
    dot4_q.c <= DOTW'(p_vv[0]) + DOTW'(p_vv[1]) + DOTW'(p_vv[2]);
    dot4_q.d <= DOTW'(p_uw[0]) + DOTW'(p_uw[1]) + DOTW'(p_uw[2]);
    dot4_q.e <= DOTW'(p_vw[0]) + DOTW'(p_vw[1]) + DOTW'(p_vw[2]);
    dot5_q   <= dot4_q;
    dot6_q   <= dot5_q;
    dot7_q   <= dot6_q;
  end

  // stages 5-6: cross products of the dot products
  logic signed [2*DOTW-1:0] p_ac, p_bb, p_be, p_cd, p_ae, p_bd;

  sd3_mul #(.W(DOTW)) u_ac (.clk_i, .a_i(dot4_q.a), .b_i(dot4_q.c), .p_o(p_ac));
  sd3_mul #(.W(DOTW)) u_bb (.clk_i, .a_i(dot4_q.b), .b_i(dot4_q.b), .p_o(p_bb));
  sd3_mul #(.W(DOTW)) u_be (.clk_i, .a_i(dot4_q.b), .b_i(dot4_q.e), .p_o(p_be));
  sd3_mul #(.W(DOTW)) u_cd (.clk_i, .a_i(dot4_q.c), .b_i(dot4_q.d), .p_o(p_cd));
  sd3_mul #(.W(DOTW)) u_ae (.clk_i, .a_i(dot4_q.a), .b_i(dot4_q.e), .p_o(p_ae));
  sd3_mul #(.W(DOTW)) u_bd (.clk_i, .a_i(dot4_q.b), .b_i(dot4_q.d), .p_o(p_bd));

  // stage 7: determinant and raw numerators
  logic signed [QW-1:0] den7_q, sn7_q, tn7_q;

  always_ff @(posedge clk_i) begin
    den7_q <= QW'(p_ac) - QW'(p_bb);
    sn7_q  <= QW'(p_be) - QW'(p_cd);
    tn7_q  <= QW'(p_ae) - QW'(p_bd);
  end

  // stage 8: clamp of the parameter on segment A
  logic signed [QW-1:0]   sn8_d, sd8_d, tn8_d, td8_d;
  logic signed [QW-1:0]   sn8_q, sd8_q, tn8_q, td8_q;
  logic signed [DOTW:0]   nd8_q, ndb8_q;
  logic signed [DOTW-1:0] a8_q;

  always_comb begin
    sn8_d = sn7_q;
    sd8_d = den7_q;
    tn8_d = tn7_q;
    td8_d = den7_q;
    if (den7_q[QW-1] || den7_q == '0) begin
      // parallel or degenerate segments
      sn8_d = '0;
      sd8_d = QW'(1);
      tn8_d = QW'(dot7_q.e);
      td8_d = QW'(dot7_q.c);
    end else if (sn7_q[QW-1]) begin
      sn8_d = '0;
      tn8_d = QW'(dot7_q.e);
      td8_d = QW'(dot7_q.c);
    end else if (sn7_q > den7_q) begin
      sn8_d = den7_q;
      tn8_d = QW'(dot7_q.e) + QW'(dot7_q.b);
      td8_d = QW'(dot7_q.c);
    end
  end

  always_ff @(posedge clk_i) begin
    sn8_q  <= sn8_d;
    sd8_q  <= sd8_d;
    tn8_q  <= tn8_d;
    td8_q  <= td8_d;
    nd8_q  <= -(DOTW + 1)'(dot7_q.d);
    ndb8_q <= (DOTW + 1)'(dot7_q.b) - (DOTW + 1)'(dot7_q.d);
    a8_q   <= dot7_q.a;
  end

  // stage 9: clamp of the parameter on segment B
  logic signed [QW-1:0] sn9_d, sd9_d, tn9_d, td9_d;
  logic signed [QW-1:0] sn9_q, sd9_q, tn9_q, td9_q;

  always_comb begin
    sn9_d = sn8_q;
    sd9_d = sd8_q;
    tn9_d = tn8_q;
    td9_d = td8_q;
    if (tn8_q[QW-1]) begin
      tn9_d = '0;
      if (nd8_q[DOTW]) begin
        sn9_d = '0;
      end else if (nd8_q > (DOTW + 1)'(a8_q)) begin
        sn9_d = sd8_q;
      end else begin
        sn9_d = QW'(nd8_q);
        sd9_d = QW'(a8_q);
      end
    end else if (tn8_q > td8_q) begin
      tn9_d = td8_q;
      if (ndb8_q[DOTW]) begin
        sn9_d = '0;
      end else if (ndb8_q > (DOTW + 1)'(a8_q)) begin
        sn9_d = sd8_q;
      end else begin
        sn9_d = QW'(ndb8_q);
        sd9_d = QW'(a8_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sn9_q <= sn9_d;
    sd9_q <= sd9_d;
    tn9_q <= tn9_d;
    td9_q <= td9_d;
  end

  // stage 10: divider setup, zero and full-scale cases
  logic [QW-1:0]        sr_q [QUOT_FRAC], sdd_q [QUOT_FRAC];
  logic [QW-1:0]        tr_q [QUOT_FRAC], tdd_q [QUOT_FRAC];
  logic [QUOT_FRAC-1:0] sq_q [QUOT_FRAC+1], tq_q [QUOT_FRAC+1];
  logic                 sz_q [QUOT_FRAC+1], sf_q [QUOT_FRAC+1];
  logic                 tz_q [QUOT_FRAC+1], tf_q [QUOT_FRAC+1];
  logic                 s_zero, t_zero;

  assign s_zero = sn9_q[QW-1] || sn9_q == '0 || sd9_q[QW-1] || sd9_q == '0;
  assign t_zero = tn9_q[QW-1] || tn9_q == '0 || td9_q[QW-1] || td9_q == '0;

  always_ff @(posedge clk_i) begin
    sr_q[0]  <= sn9_q;
    sdd_q[0] <= sd9_q;
    sq_q[0]  <= '0;
    sz_q[0]  <= s_zero;
    sf_q[0]  <= !s_zero && sn9_q >= sd9_q;
    tr_q[0]  <= tn9_q;
    tdd_q[0] <= td9_q;
    tq_q[0]  <= '0;
    tz_q[0]  <= t_zero;
    tf_q[0]  <= !t_zero && tn9_q >= td9_q;
  end

  // stages 11-42: one quotient bit per stage for both parameters
  for (genvar j = 0; j < QUOT_FRAC; j++) begin : g_div
    logic [QW-1:0] s_sh, t_sh;
    logic          s_ge, t_ge;

    assign s_sh = {sr_q[j][QW-2:0], 1'b0};
    assign t_sh = {tr_q[j][QW-2:0], 1'b0};
    assign s_ge = s_sh >= sdd_q[j];
    assign t_ge = t_sh >= tdd_q[j];

    always_ff @(posedge clk_i) begin
      sq_q[j+1] <= {sq_q[j][QUOT_FRAC-2:0], s_ge};
      tq_q[j+1] <= {tq_q[j][QUOT_FRAC-2:0], t_ge};
      sz_q[j+1] <= sz_q[j];
      sf_q[j+1] <= sf_q[j];
      tz_q[j+1] <= tz_q[j];
      tf_q[j+1] <= tf_q[j];
    end

    if (j < QUOT_FRAC - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        sr_q[j+1]  <= s_ge ? (s_sh - sdd_q[j]) : s_sh;
        tr_q[j+1]  <= t_ge ? (t_sh - tdd_q[j]) : t_sh;
        sdd_q[j+1] <= sdd_q[j];
        tdd_q[j+1] <= tdd_q[j];
      end
    end
  end

  // final parameters, zero or full scale override the quotient
  logic signed [MW-1:0] sc, tc;

  assign sc = sz_q[QUOT_FRAC] ? '0 :
              sf_q[QUOT_FRAC] ? (MW'(1) << QUOT_FRAC) : MW'(sq_q[QUOT_FRAC]);
  assign tc = tz_q[QUOT_FRAC] ? '0 :
              tf_q[QUOT_FRAC] ? (MW'(1) << QUOT_FRAC) : MW'(tq_q[QUOT_FRAC]);

  // stages 43-44: parameter times direction
  logic signed [2*MW-1:0] p_su [3], p_tv [3];
  logic signed [DPW-1:0]  dp_q [3];
  logic signed [2*DPW-1:0] p_sq [3];

  for (genvar k = 0; k < 3; k++) begin : g_cp
    sd3_mul #(.W(MW)) u_su (
      .clk_i, .a_i(sc), .b_i(MW'(u_dl_q[ST_DIV-2][k])), .p_o(p_su[k])
    );
    sd3_mul #(.W(MW)) u_tv (
      .clk_i, .a_i(tc), .b_i(MW'(v_dl_q[ST_DIV-2][k])), .p_o(p_tv[k])
    );

    // stage 45: closest-point difference per axis
    always_ff @(posedge clk_i) begin
      dp_q[k] <= (DPW'(w_dl_q[ST_DP-2][k]) <<< QUOT_FRAC) + DPW'(p_su[k])
               - DPW'(p_tv[k]);
    end

    // stages 46-47: squares
    sd3_mul #(.W(DPW)) u_sq (.clk_i, .a_i(dp_q[k]), .b_i(dp_q[k]), .p_o(p_sq[k]));
  end

  // stage 48: squared length, scaled down to the result format
  logic signed [SW-1:0]  ssum;
  logic [RW-1:0]         rm_q [DIST_BITS];
  logic [DIST_BITS-1:0]  rt_q [DIST_BITS+1];

  assign ssum = SW'(p_sq[0]) + SW'(p_sq[1]) + SW'(p_sq[2]);

  always_ff @(posedge clk_i) begin
    rm_q[0] <= RW'(ssum[SW-1:2*QUOT_FRAC]);
    rt_q[0] <= '0;
  end

  // stages 49-81: square root, one result bit per stage from the top
  for (genvar j = 0; j < DIST_BITS; j++) begin : g_sqrt
    localparam int unsigned K = DIST_BITS - 1 - j;
    logic [RW-1:0] term;
    logic          take;

    assign term = (RW'(rt_q[j]) << (K + 1)) + (RW'(1) << (2 * K));
    assign take = rm_q[j] >= term;

    always_ff @(posedge clk_i) begin
      rt_q[j+1] <= take ? (rt_q[j] | (DIST_BITS'(1) << K)) : rt_q[j];
    end

    if (j < DIST_BITS - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        rm_q[j+1] <= take ? (rm_q[j] - term) : rm_q[j];
      end
    end
  end

  assign distance_o = rt_q[DIST_BITS];

endmodule
`default_nettype wire

>>> rtl/sd3_chk.sv
// port-level checker for the 3d segment distance pipeline, with its bind
`default_nettype none
module sd3_chk
  import sd3_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start,
  input logic                         busy,
  input logic signed [COORD_BITS-1:0] seg_a_second_x_i,
  input logic signed [COORD_BITS-1:0] seg_a_second_y_i,
  input logic signed [COORD_BITS-1:0] seg_a_second_z_i,
  input logic signed [COORD_BITS-1:0] seg_b_second_x_i,
  input logic signed [COORD_BITS-1:0] seg_b_second_y_i,
  input logic signed [COORD_BITS-1:0] seg_b_second_z_i,
  input logic                         done_o,
  input logic [DIST_BITS-1:0]         distance_o
);

  // every accepted request yields a result after the fixed latency
  a_req_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##PIPE_LAT done_o)
    else $error("request produced no result");

  // no result without a request at the matching cycle
  a_done_from_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, PIPE_LAT) && !$past(busy, PIPE_LAT))
    else $error("result strobe without request");

  // segments sharing their second endpoint touch
  a_shared_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && seg_a_second_x_i == seg_b_second_x_i
      && seg_a_second_y_i == seg_b_second_y_i
      && seg_a_second_z_i == seg_b_second_z_i
    |-> ##PIPE_LAT distance_o == '0)
    else $error("touching segments gave nonzero distance");

endmodule

bind segment_distance_3d sd3_chk #(.COORD_BITS(COORD_BITS)) u_sd3_chk (.*);
`default_nettype wire
